[src/slrng_pkg.sv]
// Shared constants and types of the shuffled Lehmer random number generator.
package slrng_pkg;

   localparam int TABLE_SIZE_DEF = 32;

   localparam logic [14:0] LEH_MUL = 15'd16807;
   localparam logic [30:0] LEH_MOD = 31'h7FFF_FFFF;

   localparam logic REQ_DRAW = 1'b0;
   localparam logic REQ_LOAD = 1'b1;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_INIT_MUL,
      FSM_INIT_RED,
      FSM_DRAW_MUL,
      FSM_DRAW_RED,
      FSM_DIV,
      FSM_READ,
      FSM_WRITE
   } fsm_type;

endpackage

[src/slrng_mulmod.sv]
// Shared Lehmer step unit: registered product by 16807, then reduction modulo 2^31-1.
module slrng_mulmod (
   input  logic        clock,
   input  logic        start,
   input  logic [30:0] operand,
   output logic [30:0] result
);

   logic [45:0] prod_ff;
   logic [45:0] prod_in;
   logic [31:0] fold;

   assign prod_in = 46'(slrng_pkg::LEH_MUL) * 46'(operand);

   always_ff @(posedge clock) begin
      if (start) begin
         prod_ff <= prod_in;
      end
   end

   // The high part weighs 2^31, which is congruent to 1, so it folds onto the low part.
   assign fold = {1'b0, prod_ff[30:0]} + {17'd0, prod_ff[45:31]};

   always_comb begin
      if (fold >= {1'b0, slrng_pkg::LEH_MOD}) begin
         result = 31'(fold - {1'b0, slrng_pkg::LEH_MOD});
      end else begin
         result = fold[30:0];
      end
   end

endmodule

[src/slrng_table.sv]
// Shuffle table memory with one write port and one registered read port.
module slrng_table #(
   parameter int DEPTH = slrng_pkg::TABLE_SIZE_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [30:0]              wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [30:0]              rd_data
);

   logic [30:0] mem_ff [DEPTH];
   logic [30:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/shuffled_lehmer_rng.sv]
// Top level of the shuffled Lehmer random number generator with its sequencer.
//
// Minimal-standard Lehmer generator (16807 * s mod 2^31-1) behind a Bays-Durham shuffle
// table of TABLE_SIZE entries. A load beat (req_type = 1) stores the signed seed; it gives
// no response. A draw beat gives one response beat and passes through the accepting state,
// the multiply and the reduce step in the shared unit, the reciprocal multiplication that
// forms the table index, then a read and a write of the table memory. When the state is
// not positive or the last pick is zero, the draw first rebuilds the table, stepping the
// generator and filling the entries from the top down. The input side is ready only
// between items; a finished result waits in the output register while the next beat is
// taken, and the table write of the next draw waits for as long as that result is still
// held.
module shuffled_lehmer_rng #(
   parameter int TABLE_SIZE = slrng_pkg::TABLE_SIZE_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_type,
   input  logic signed [31:0] req_seed_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [30:0]        rsp_random_value
);

   localparam int AW = $clog2(TABLE_SIZE);
   localparam int CW = $clog2(TABLE_SIZE + 8);
   localparam int QW = $clog2(TABLE_SIZE) + 1;
   localparam logic [30:0] NDIV = 31'(1 + (64'h7FFF_FFFE / TABLE_SIZE));
   localparam int RSH = 31 + $clog2(NDIV);
   localparam logic [63:0] RECIP_FULL = ((64'd1 << RSH) + 64'(NDIV) - 64'd1) / 64'(NDIV);
   localparam logic [31:0] RECIP_M = RECIP_FULL[31:0];

   slrng_pkg::fsm_type fsm_ff, fsm_in;

   logic [31:0]    state_ff, state_in;
   logic [30:0]    pick_ff, pick_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [QW-1:0]  quo_ff, quo_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [30:0]    rsp_value_ff, rsp_value_in;

   logic           mul_start;
   logic [30:0]    mul_result;
   logic           wr_en;
   logic [AW-1:0]  wr_addr;
   logic [30:0]    wr_data;
   logic           rd_en;
   logic [30:0]    rd_data;
   logic [AW-1:0]  tbl_index;
   logic           need_init;
   logic [31:0]    neg_state;
   logic [31:0]    init_state;
   logic [63:0]    recip_prod;

   slrng_mulmod u_mulmod (
      .clock   (clock),
      .start   (mul_start),
      .operand (state_ff[30:0]),
      .result  (mul_result)
   );

   slrng_table #(
      .DEPTH (TABLE_SIZE)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (tbl_index),
      .rd_data (rd_data)
   );

   assign need_init  = (state_ff == 32'd0) || state_ff[31] || (pick_ff == 31'd0);
   assign neg_state  = 32'd0 - state_ff;
   assign init_state = ((neg_state == 32'd0) || neg_state[31]) ? 32'd1 : neg_state;
   // The rounded-up reciprocal of the index divisor gives the exact quotient for any pick.
   assign recip_prod = 64'(pick_ff) * 64'(RECIP_M);
   assign tbl_index  = (quo_ff >= QW'(TABLE_SIZE)) ? AW'(TABLE_SIZE - 1) : quo_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff       <= slrng_pkg::FSM_IDLE;
         state_ff     <= 32'd0;
         pick_ff      <= 31'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fsm_ff       <= fsm_in;
         state_ff     <= state_in;
         pick_ff      <= pick_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cnt_ff       <= cnt_in;
      quo_ff       <= quo_in;
      rsp_value_ff <= rsp_value_in;
   end

   always_comb begin
      fsm_in       = fsm_ff;
      state_in     = state_ff;
      pick_in      = pick_ff;
      cnt_in       = cnt_ff;
      quo_in       = quo_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      mul_start    = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = tbl_index;
      wr_data      = state_ff[30:0];
      rd_en        = 1'b0;
      unique case (fsm_ff)
         slrng_pkg::FSM_IDLE: begin
            if (req_valid) begin
               if (req_type == slrng_pkg::REQ_LOAD) begin
                  state_in = $unsigned(req_seed_value);
               end else if (need_init) begin
                  state_in = init_state;
                  cnt_in   = CW'(TABLE_SIZE + 7);
                  fsm_in   = slrng_pkg::FSM_INIT_MUL;
               end else begin
                  fsm_in = slrng_pkg::FSM_DRAW_MUL;
               end
            end
         end
         slrng_pkg::FSM_INIT_MUL: begin
            mul_start = 1'b1;
            fsm_in    = slrng_pkg::FSM_INIT_RED;
         end
         slrng_pkg::FSM_INIT_RED: begin
            state_in = {1'b0, mul_result};
            // The last steps fill the table from the top entry down to entry 0.
            if (cnt_ff < CW'(TABLE_SIZE)) begin
               wr_en   = 1'b1;
               wr_addr = cnt_ff[AW-1:0];
               wr_data = mul_result;
            end
            if (cnt_ff == '0) begin
               pick_in = mul_result;
               fsm_in  = slrng_pkg::FSM_DRAW_MUL;
            end else begin
               cnt_in = cnt_ff - 1'b1;
               fsm_in = slrng_pkg::FSM_INIT_MUL;
            end
         end
         slrng_pkg::FSM_DRAW_MUL: begin
            mul_start = 1'b1;
            fsm_in    = slrng_pkg::FSM_DRAW_RED;
         end
         slrng_pkg::FSM_DRAW_RED: begin
            state_in = {1'b0, mul_result};
            fsm_in   = slrng_pkg::FSM_DIV;
         end
         slrng_pkg::FSM_DIV: begin
            quo_in = recip_prod[RSH +: QW];
            fsm_in = slrng_pkg::FSM_READ;
         end
         slrng_pkg::FSM_READ: begin
            rd_en  = 1'b1;
            fsm_in = slrng_pkg::FSM_WRITE;
         end
         slrng_pkg::FSM_WRITE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               wr_en        = 1'b1;
               pick_in      = rd_data;
               rsp_valid_in = 1'b1;
               rsp_value_in = rd_data;
               fsm_in       = slrng_pkg::FSM_IDLE;
            end
         end
      endcase
   end

   assign req_ready        = (fsm_ff == slrng_pkg::FSM_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_random_value = rsp_value_ff;

`ifndef SYNTHESIS
   a_draw_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_type == slrng_pkg::REQ_DRAW) |=>
      (fsm_ff == slrng_pkg::FSM_INIT_MUL || fsm_ff == slrng_pkg::FSM_DRAW_MUL))
      else $error("draw beat did not start a generator step");

   a_load_stores: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_type == slrng_pkg::REQ_LOAD) |=>
      (fsm_ff == slrng_pkg::FSM_IDLE && state_ff == $past($unsigned(req_seed_value))))
      else $error("load beat did not store the seed");

   a_state_reduced: assert property (@(posedge clock) disable iff (reset)
      (fsm_ff == slrng_pkg::FSM_DIV) |-> !state_ff[31])
      else $error("generator state not reduced before the index divide");

   a_rsp_from_write: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(fsm_ff) == slrng_pkg::FSM_WRITE))
      else $error("response raised outside the table write");
`endif

endmodule
